[sv/isa_pkg.sv]
// Shared payload types for the integer array sorter.
package isa_pkg;

    // One input transfer: an integer of the set and the end-of-set mark.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    // One result transfer: the next integer in ascending order and its flags.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               dropped;
    } t_out_item;

endpackage

[sv/isa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module isa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/integer_array_sorter.sv]
// Insertion sorter: keeps a set of signed integers in a RAM in ascending order.
// An integer that is not last keeps busy high after its transfer while the insertion walk
// shifts each stored entry larger than it up one place in the RAM, then places the integer.
// A last integer also keeps busy high through the read-out of the set: one result per cycle.
// A dropped integer (store full) is not inserted. The RAM read port sets the pace of both.
// Reset empties the set and clears the dropped flag; the receiver cannot stall results.
module integer_array_sorter #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  isa_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output isa_pkg::t_out_item  o_result
);

    import isa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]         r_state;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic               r_last;
    logic signed [31:0] r_val;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_k;
    logic               r_pend;
    logic               r_pend_last;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    logic               accept;
    logic               full;
    logic               shift;
    logic [AW-1:0]      last_idx;

    assign accept   = start && !busy;
    assign full     = (r_count == CW'(DEPTH));
    assign shift    = ($signed(ram_rdata) > r_val);
    assign last_idx = AW'(r_count - CW'(1));
    assign busy     = (r_state != S_IDLE);

    // Sorted store.
    isa_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM port control: shift the larger entry up, or place the new value.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_raddr = r_k;
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(r_count - CW'(1));
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_wdata = shift ? ram_rdata : r_val;
                ram_raddr = r_pos - AW'(2);
            end
            S_PLACE: begin
                ram_we = 1'b1;
            end
            S_OUT, S_DRAIN: begin
                ram_raddr = r_k;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer for insertion and read-out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            // A read issued in the output state shows up as a result in the following cycle.
            r_pend      <= (r_state == S_OUT);
            r_pend_last <= (r_state == S_OUT) && (r_k == last_idx);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val  <= i_item.value;
                        r_last <= i_item.last;
                        r_pos  <= AW'(r_count);
                        r_k    <= '0;
                        if (full) begin
                            r_ovf <= 1'b1;
                            if (i_item.last) begin
                                r_state <= S_OUT;
                            end
                        end else if (r_count == '0) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_state <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    // The read data holds the entry just below the current hole.
                    if (shift) begin
                        r_pos <= r_pos - AW'(1);
                        if (r_pos == AW'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= r_last ? S_OUT : S_IDLE;
                    end
                end
                S_PLACE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (r_k == last_idx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_DRAIN: begin
                    // The final result is on the ports; empty the set.
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Results come straight from the registered read data.
    assign o_strobe              = r_pend;
    assign o_result.sorted_value = $signed(ram_rdata);
    assign o_result.last_out     = r_pend_last;
    assign o_result.dropped      = r_ovf;

endmodule
